/* rtl/core/ura_pkg.sv */
// ----------------------------------------------------------------------------
// ura_pkg
// shared types, constants and digit helpers for the radix to ascii converter
// ----------------------------------------------------------------------------
package ura_pkg;

    localparam int VALUE_WIDTH_DEF = 64;
    localparam int INPUT_WIDTH     = 64;
    localparam int RADIX_W         = 6;
    localparam int CHAR_W          = 7;
    localparam int COUNT_W         = 7;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
    localparam logic [RADIX_W-1:0] DIGIT_TEN = 6'd10;
    localparam logic [CHAR_W-1:0]  ASCII_ZERO = 7'h30;
    localparam logic [CHAR_W-1:0]  ASCII_A    = 7'h41;

    typedef struct packed {
        logic [INPUT_WIDTH-1:0] value;
        logic [RADIX_W-1:0]     radix;
    } item_t;

    typedef struct packed {
        logic [CHAR_W-1:0]  digit_char;
        logic               is_last;
        logic [COUNT_W-1:0] digit_count;
    } digit_t;

    // status from the serial divider back to the sequencer
    typedef struct packed {
        logic               done;
        logic [RADIX_W-1:0] rem;
    } div_stat_t;

    function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] c;
        begin
            if (r < RADIX_MIN)
            begin
                c = RADIX_MIN;
            end
            else if (r > RADIX_MAX)
            begin
                c = RADIX_MAX;
            end
            else
            begin
                c = r;
            end
            return c;
        end
    endfunction

    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] c;
        begin
            if (d < DIGIT_TEN)
            begin
                c = ASCII_ZERO + {1'b0, d};
            end
            else
            begin
                c = ASCII_A + {1'b0, d - DIGIT_TEN};
            end
            return c;
        end
    endfunction

endpackage

/* rtl/core/ura_div.sv */
// ----------------------------------------------------------------------------
// ura_div
// bit-serial restoring divider by a small radix, one quotient bit per cycle
// ----------------------------------------------------------------------------
module ura_div
    import ura_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [VALUE_WIDTH-1:0] dividend,
    input  logic [RADIX_W-1:0]     divisor,
    output logic [VALUE_WIDTH-1:0] quotient,
    output div_stat_t              stat
);

    localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

    logic [VALUE_WIDTH-1:0] quot_reg, quot_next;
    logic [RADIX_W-1:0]     rem_reg, rem_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   done_reg, done_next;

    logic [RADIX_W:0]       rem_shift;
    logic [RADIX_W:0]       rem_diff;
    logic                   fits;

    // partial remainder stays below the divisor, so one spare bit is enough
    assign rem_shift = {rem_reg, quot_reg[VALUE_WIDTH-1]};
    assign fits      = rem_shift >= {1'b0, divisor};
    assign rem_diff  = rem_shift - {1'b0, divisor};

    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            quot_next = dividend;
            rem_next  = '0;
            cnt_next  = CNT_W'(VALUE_WIDTH);
        end
        else if (cnt_reg != '0)
        begin
            quot_next = {quot_reg[VALUE_WIDTH-2:0], fits};
            rem_next  = fits ? rem_diff[RADIX_W-1:0] : rem_shift[RADIX_W-1:0];
            cnt_next  = cnt_reg - CNT_W'(1);
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
    end

    assign quotient  = quot_reg;
    assign stat.done = done_reg;
    assign stat.rem  = rem_reg;

endmodule

/* rtl/core/ura_digit_buf.sv */
// ----------------------------------------------------------------------------
// ura_digit_buf
// digit store, one write and one registered read port
// ----------------------------------------------------------------------------
module ura_digit_buf
    import ura_pkg::*;
#(
    parameter int DEPTH = VALUE_WIDTH_DEF
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [RADIX_W-1:0]       wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [RADIX_W-1:0]       rd_data
);

    logic [RADIX_W-1:0] mem [DEPTH];
    logic [RADIX_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/unsigned_radix_to_ascii.sv */
// ----------------------------------------------------------------------------
// unsigned_radix_to_ascii
// unsigned integer to ascii text in radix 2..36, digit-serial
// ----------------------------------------------------------------------------
// usage
//   item channel: item_valid / item_ready with item.value and item.radix.
//   only the low VALUE_WIDTH bits of the value are used; the radix is
//   clamped into 2..36. item_ready is high only while the block is idle.
//   digit channel: digit_valid / digit_ready, one request per digit, most
//   significant first, each carrying the ascii character, the last flag and
//   the total digit count. a zero value gives the single digit '0'.
// operation
//   each digit costs one pass of the bit-serial divider; conversion runs
//   all passes first, then readout fetches each digit from the digit store's
//   registered read port (S_FETCH, S_LOAD, S_OUT) plus any stall time.
// reset and stall
//   reset returns the sequencer to idle and drops digit_valid; no clearing
//   pass is needed. while digit_ready is low the current digit holds still
//   and no new request is taken.
// ----------------------------------------------------------------------------
module unsigned_radix_to_ascii
    import ura_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   item_valid,
    output logic   item_ready,
    input  item_t  item,
    output logic   digit_valid,
    input  logic   digit_ready,
    output digit_t digit
);

    localparam int ADDR_W = $clog2(VALUE_WIDTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_FETCH,
        S_LOAD,
        S_OUT
    } state_t;

    state_t                 state_reg, state_next;
    logic [RADIX_W-1:0]     radix_reg, radix_next;
    logic [COUNT_W-1:0]     count_reg, count_next;
    logic [ADDR_W-1:0]      rd_idx_reg, rd_idx_next;
    logic                   out_valid_reg, out_valid_next;
    digit_t                 out_reg, out_next;

    logic                   div_start;
    logic [VALUE_WIDTH-1:0] div_dividend;
    logic [VALUE_WIDTH-1:0] div_quot;
    div_stat_t              div_stat;
    logic                   buf_wr_en;
    logic [RADIX_W-1:0]     buf_rd_data;
    logic                   conv_end;

    // divider: each pass yields one digit as remainder, quotient is fed back
    ura_div #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (radix_reg),
        .quotient (div_quot),
        .stat     (div_stat)
    );

    // digits land least significant first, read back in reverse
    ura_digit_buf #(
        .DEPTH (VALUE_WIDTH)
    ) u_buf (
        .clk     (clk),
        .wr_en   (buf_wr_en),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data (div_stat.rem),
        .rd_addr (rd_idx_reg),
        .rd_data (buf_rd_data)
    );

    assign buf_wr_en = (state_reg == S_DIV) && div_stat.done;
    // stop once the quotient runs out or every digit slot is used
    assign conv_end  = (div_quot == '0) || (count_reg == COUNT_W'(VALUE_WIDTH - 1));

    always_comb
    begin
        state_next     = state_reg;
        radix_next     = radix_reg;
        count_next     = count_reg;
        rd_idx_next    = rd_idx_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        div_start      = 1'b0;
        div_dividend   = div_quot;
        case (state_reg)
            S_IDLE:
            begin
                div_dividend = item.value[VALUE_WIDTH-1:0];
                if (item_valid)
                begin
                    div_start  = 1'b1;
                    radix_next = clamp_radix(item.radix);
                    count_next = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    count_next = count_reg + COUNT_W'(1);
                    if (conv_end)
                    begin
                        rd_idx_next = count_reg[ADDR_W-1:0];
                        state_next  = S_FETCH;
                    end
                    else
                    begin
                        div_start = 1'b1;
                    end
                end
            end
            S_FETCH:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                out_next.digit_char  = digit_to_ascii(buf_rd_data);
                out_next.is_last     = (rd_idx_reg == '0);
                out_next.digit_count = count_reg;
                out_valid_next       = 1'b1;
                state_next           = S_OUT;
            end
            S_OUT:
            begin
                if (digit_ready)
                begin
                    out_valid_next = 1'b0;
                    if (rd_idx_reg == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        rd_idx_next = rd_idx_reg - ADDR_W'(1);
                        state_next  = S_FETCH;
                    end
                end
            end
            default:
            begin
                state_next     = S_IDLE;
                out_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
            radix_reg     <= RADIX_MIN;
            out_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_idx_reg    <= rd_idx_next;
            out_valid_reg <= out_valid_next;
            radix_reg     <= radix_next;
            out_reg       <= out_next;
        end
    end

    assign item_ready  = (state_reg == S_IDLE);
    assign digit_valid = out_valid_reg;
    assign digit       = out_reg;

endmodule

/* rtl/core/ura_checker.sv */
// ----------------------------------------------------------------------------
// ura_checker
// port-level checks for the radix to ascii converter, bound to the top level
// ----------------------------------------------------------------------------
module ura_checker
    import ura_pkg::*;
(
    input logic   clk,
    input logic   rst_n,
    input logic   item_valid,
    input logic   item_ready,
    input item_t  item,
    input logic   digit_valid,
    input logic   digit_ready,
    input digit_t digit
);

    // a stalled digit request holds
    a_digit_hold: assert property (@(posedge clk) disable iff (!rst_n)
        digit_valid && !digit_ready |=> digit_valid && $stable(digit))
        else $error("digit request changed while stalled");

    // no new value is taken while digits are still going out
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        item_ready |-> !digit_valid)
        else $error("item ready while digits pending");

    // the last digit closes the value
    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        digit_valid && digit_ready && digit.is_last |=> !digit_valid)
        else $error("digit request after the last digit");

    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        digit_valid |-> (digit.digit_char >= ASCII_ZERO && digit.digit_char <= 7'h39) ||
                        (digit.digit_char >= ASCII_A && digit.digit_char <= 7'h5A))
        else $error("digit character out of range");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        digit_valid |-> digit.digit_count != '0 && digit.digit_count <= 7'd64)
        else $error("digit count out of range");

endmodule

bind unsigned_radix_to_ascii ura_checker u_ura_checker (.*);
